FILE: src/sgd_matrix_factorization_update_unit_macros.svh
// assertion macros for the sgd matrix factorisation update unit
// no dependencies; included by the modules that carry assertions
`ifndef SGD_MATRIX_FACTORIZATION_UPDATE_UNIT_MACROS_SVH
`define SGD_MATRIX_FACTORIZATION_UPDATE_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define SGDMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgdmf assertion failed");

// consequent must hold in the following cycle
`define SGDMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgdmf assertion failed");

`endif

FILE: src/sgdmf_pkg.sv
// shared types, constants and saturation helper for the sgd update unit
// no dependencies
package sgdmf_pkg;

   localparam int USERS   = 1024;
   localparam int ITEMS   = 1024;
   localparam int FACTORS = 16;

   localparam int Q_W      = 24;
   localparam int K_W      = (FACTORS > 1) ? $clog2(FACTORS) : 1;
   localparam int U_ROW_W  = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int I_ROW_W  = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int U_ADDR_W = $clog2(USERS * FACTORS);
   localparam int I_ADDR_W = $clog2(ITEMS * FACTORS);
   localparam int ACC_W    = 2 * Q_W + K_W + 1;

   localparam logic signed [63:0] Q_MAX = 64'sd8388607;
   localparam logic signed [63:0] Q_MIN = -64'sd8388608;

   typedef enum logic [1:0] {
      OP_LOAD_USER = 2'd0,
      OP_LOAD_ITEM = 2'd1,
      OP_PREDICT   = 2'd2,
      OP_TRAIN     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_DOT_WAIT,
      ST_ERR,
      ST_UPD,
      ST_UPD_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic [9:0]              user_index;
      logic [9:0]              item_index;
      logic [3:0]              factor_index;
      logic signed [Q_W-1:0]   in_value;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   out_value;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   value;
      logic                    sat;
   } sat_type;

   // result of one element update pipeline
   typedef struct packed {
      logic                    busy;
      logic                    wr_en;
      logic [K_W-1:0]          k;
      logic signed [Q_W-1:0]   value;
      logic                    sat;
   } upd_out_type;

   // clamp a wide value to Q8.16
   function automatic sat_type clamp_q(input logic signed [63:0] x);
      sat_type r;
      if (x > Q_MAX) begin
         r.value = Q_MAX[Q_W-1:0];
         r.sat   = 1'b1;
      end else if (x < Q_MIN) begin
         r.value = Q_MIN[Q_W-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = x[Q_W-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: src/sgdmf_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
module sgdmf_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/sgdmf_update.sv
// pipelined single element update x += a*(2*e*y - b*x), saturated to Q8.16
// depends on sgdmf_pkg
module sgdmf_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [sgdmf_pkg::K_W-1:0]       in_k,
   input  logic signed [sgdmf_pkg::Q_W-1:0] x,
   input  logic signed [sgdmf_pkg::Q_W-1:0] y,
   input  logic signed [sgdmf_pkg::Q_W-1:0] err,
   input  logic [15:0]                     learn_rate,
   input  logic [15:0]                     regularization,
   output sgdmf_pkg::upd_out_type          result
);

   logic                            v1_ff, v2_ff, v3_ff;
   logic [sgdmf_pkg::K_W-1:0]       k1_ff, k2_ff, k3_ff;
   logic signed [sgdmf_pkg::Q_W-1:0] x1_ff, x2_ff, x3_ff;
   logic signed [47:0]              ey_ff;
   logic signed [40:0]              bx_ff;
   logic signed [48:0]              t_ff;
   logic signed [65:0]              at_ff;
   logic signed [65:0]              step;
   logic signed [63:0]              sum;
   sgdmf_pkg::sat_type              clamped;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: error and regularisation products
   always_ff @(posedge clock) begin
      ey_ff <= err * y;
      bx_ff <= $signed({1'b0, regularization}) * x;
      x1_ff <= x;
      k1_ff <= in_k;
   end

   // stage 2: gradient term at scale 2^-32
   always_ff @(posedge clock) begin
      t_ff  <= (49'(ey_ff) <<< 1) - 49'(bx_ff);
      x2_ff <= x1_ff;
      k2_ff <= k1_ff;
   end

   // stage 3: scale by learning rate
   always_ff @(posedge clock) begin
      at_ff <= $signed({1'b0, learn_rate}) * t_ff;
      x3_ff <= x2_ff;
      k3_ff <= k2_ff;
   end

   // round half up to scale 2^-16, add and saturate
   assign step    = (at_ff + (66'sd1 <<< 31)) >>> 32;
   assign sum     = 64'(x3_ff) + $signed(step[63:0]);
   assign clamped = sgdmf_pkg::clamp_q(sum);

   assign result.busy  = v1_ff | v2_ff | v3_ff;
   assign result.wr_en = v3_ff;
   assign result.k     = k3_ff;
   assign result.value = clamped.value;
   assign result.sat   = clamped.sat;

endmodule

FILE: src/sgd_matrix_factorization_update_unit.sv
// top level of the sgd matrix factorisation update unit: sequencer, dot product, csr
// depends on sgdmf_pkg, sgdmf_ram, sgdmf_update and the macros header
`include "sgd_matrix_factorization_update_unit_macros.svh"

// One request is taken when start is high and busy is low; its result appears
// on rsp_data with rsp_strobe, which is high for exactly one cycle, and the receiver cannot stall.
// A load goes straight to the response state; a predict and a train are paced by the
// single read port of each factor memory: one element per cycle for the dot product,
// then one per cycle for a train's read-modify-write pass through the update pipeline.
// The factor memories are not cleared; a row must be loaded before use.
module sgd_matrix_factorization_update_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sgdmf_pkg::req_type req_data,
   output logic               rsp_strobe,
   output sgdmf_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int K_W = sgdmf_pkg::K_W;
   localparam int Q_W = sgdmf_pkg::Q_W;
   localparam int UA_W = sgdmf_pkg::U_ADDR_W;
   localparam int IA_W = sgdmf_pkg::I_ADDR_W;

   sgdmf_pkg::state_type state_ff, state_in;

   logic [15:0]              lr_ff, reg_ff;
   logic [1:0]               op_ff;
   logic signed [Q_W-1:0]    val_ff;
   logic [UA_W-1:0]          ubase_ff, ubase_req;
   logic [IA_W-1:0]          ibase_ff, ibase_req;
   logic [K_W-1:0]           k_ff;
   logic                     d1_v_ff, d2_v_ff, u1_v_ff;
   logic [K_W-1:0]           u1_k_ff;
   logic signed [47:0]       prod_ff;
   logic signed [sgdmf_pkg::ACC_W-1:0] acc_ff;
   logic signed [Q_W-1:0]    err_ff, result_ff;
   logic                     flag_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   sgdmf_pkg::rsp_type       rsp_data_ff;

   logic                     accept, cfg_wr, k_last;
   logic                     issue_dot, issue_upd;
   logic                     load_ok;
   logic [Q_W-1:0]           p_rd, q_rd;
   logic                     u_wr_en, i_wr_en;
   logic [UA_W-1:0]          u_wr_addr;
   logic [IA_W-1:0]          i_wr_addr;
   logic [Q_W-1:0]           u_wr_data, i_wr_data;
   sgdmf_pkg::upd_out_type   p_upd, q_upd;
   sgdmf_pkg::sat_type       pred_sat, err_sat;
   logic signed [63:0]       acc_round;

   assign accept  = start && !busy;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign k_last  = (k_ff == K_W'(sgdmf_pkg::FACTORS - 1));
   assign load_ok = (int'(req_data.factor_index) < sgdmf_pkg::FACTORS);

   // row base addresses of the incoming request
   assign ubase_req = UA_W'(UA_W'(req_data.user_index % sgdmf_pkg::USERS)
                      * UA_W'(sgdmf_pkg::FACTORS));
   assign ibase_req = IA_W'(IA_W'(req_data.item_index % sgdmf_pkg::ITEMS)
                      * IA_W'(sgdmf_pkg::FACTORS));

   // csr registers
   assign pready = 1'b1;
   assign prdata = paddr[2] ? {16'd0, reg_ff} : {16'd0, lr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= 16'd13;
         reg_ff <= 16'd1311;
      end else if (cfg_wr) begin
         if (paddr[2]) begin
            reg_ff <= pwdata[15:0];
         end else begin
            lr_ff <= pwdata[15:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgdmf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == sgdmf_pkg::OP_LOAD_USER ||
                   req_data.operation == sgdmf_pkg::OP_LOAD_ITEM) begin
                  state_in = sgdmf_pkg::ST_RESP;
               end else begin
                  state_in = sgdmf_pkg::ST_DOT;
               end
            end
         end
         sgdmf_pkg::ST_DOT: begin
            if (k_last) state_in = sgdmf_pkg::ST_DOT_WAIT;
         end
         sgdmf_pkg::ST_DOT_WAIT: begin
            if (!d1_v_ff && !d2_v_ff) state_in = sgdmf_pkg::ST_ERR;
         end
         sgdmf_pkg::ST_ERR: begin
            if (op_ff == sgdmf_pkg::OP_PREDICT) begin
               state_in = sgdmf_pkg::ST_RESP;
            end else begin
               state_in = sgdmf_pkg::ST_UPD;
            end
         end
         sgdmf_pkg::ST_UPD: begin
            if (k_last) state_in = sgdmf_pkg::ST_UPD_WAIT;
         end
         sgdmf_pkg::ST_UPD_WAIT: begin
            if (!u1_v_ff && !p_upd.busy) state_in = sgdmf_pkg::ST_RESP;
         end
         sgdmf_pkg::ST_RESP: begin
            state_in = sgdmf_pkg::ST_IDLE;
         end
         default: state_in = sgdmf_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy         = 1'b1;
      issue_dot    = 1'b0;
      issue_upd    = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         sgdmf_pkg::ST_IDLE: busy         = 1'b0;
         sgdmf_pkg::ST_DOT:  issue_dot    = 1'b1;
         sgdmf_pkg::ST_UPD:  issue_upd    = 1'b1;
         sgdmf_pkg::ST_RESP: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgdmf_pkg::ST_IDLE;
         k_ff         <= '0;
         d1_v_ff      <= 1'b0;
         d2_v_ff      <= 1'b0;
         u1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         d1_v_ff      <= issue_dot;
         d2_v_ff      <= d1_v_ff;
         u1_v_ff      <= issue_upd;
         rsp_valid_ff <= rsp_valid_in;
         if (issue_dot || issue_upd) begin
            k_ff <= k_last ? '0 : k_ff + K_W'(1);
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_data.operation;
         val_ff   <= req_data.in_value;
         ubase_ff <= ubase_req;
         ibase_ff <= ibase_req;
      end
      u1_k_ff <= k_ff;
   end

   // dot product: one product per cycle into the accumulator
   always_ff @(posedge clock) begin
      prod_ff <= $signed(p_rd) * $signed(q_rd);
      if (accept) begin
         acc_ff <= '0;
      end else if (d2_v_ff) begin
         acc_ff <= acc_ff + sgdmf_pkg::ACC_W'(prod_ff);
      end
   end

   // prediction rounding and error
   assign acc_round = (64'(acc_ff) + 64'sd32768) >>> 16;
   assign pred_sat  = sgdmf_pkg::clamp_q(acc_round);
   assign err_sat   = sgdmf_pkg::clamp_q(64'(val_ff) - 64'(pred_sat.value));

   // result and flag
   always_ff @(posedge clock) begin
      if (accept) begin
         flag_ff   <= 1'b0;
         result_ff <= '0;
      end else if (state_ff == sgdmf_pkg::ST_ERR) begin
         err_ff  <= err_sat.value;
         if (op_ff == sgdmf_pkg::OP_PREDICT) begin
            result_ff <= pred_sat.value;
            flag_ff   <= pred_sat.sat;
         end else begin
            result_ff <= err_sat.value;
            flag_ff   <= pred_sat.sat | err_sat.sat;
         end
      end else if ((p_upd.wr_en && p_upd.sat) || (q_upd.wr_en && q_upd.sat)) begin
         flag_ff <= 1'b1;
      end
      if (rsp_valid_in) begin
         rsp_data_ff.out_value <= result_ff;
         rsp_data_ff.saturated <= flag_ff;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // memory write selection: loads when idle, updates otherwise
   assign u_wr_en   = (accept && load_ok && req_data.operation == sgdmf_pkg::OP_LOAD_USER)
                      || p_upd.wr_en;
   assign i_wr_en   = (accept && load_ok && req_data.operation == sgdmf_pkg::OP_LOAD_ITEM)
                      || q_upd.wr_en;
   assign u_wr_addr = p_upd.wr_en ? UA_W'(ubase_ff + UA_W'(p_upd.k))
                                  : UA_W'(ubase_req + UA_W'(req_data.factor_index));
   assign i_wr_addr = q_upd.wr_en ? IA_W'(ibase_ff + IA_W'(q_upd.k))
                                  : IA_W'(ibase_req + IA_W'(req_data.factor_index));
   assign u_wr_data = p_upd.wr_en ? p_upd.value : req_data.in_value;
   assign i_wr_data = q_upd.wr_en ? q_upd.value : req_data.in_value;

   sgdmf_ram #(
      .DEPTH(sgdmf_pkg::USERS * sgdmf_pkg::FACTORS),
      .WIDTH(Q_W)
   ) u_user_ram (
      .clock   (clock),
      .wr_en   (u_wr_en),
      .wr_addr (u_wr_addr),
      .wr_data (u_wr_data),
      .rd_en   (issue_dot || issue_upd),
      .rd_addr (UA_W'(ubase_ff + UA_W'(k_ff))),
      .rd_data (p_rd)
   );

   sgdmf_ram #(
      .DEPTH(sgdmf_pkg::ITEMS * sgdmf_pkg::FACTORS),
      .WIDTH(Q_W)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (i_wr_en),
      .wr_addr (i_wr_addr),
      .wr_data (i_wr_data),
      .rd_en   (issue_dot || issue_upd),
      .rd_addr (IA_W'(ibase_ff + IA_W'(k_ff))),
      .rd_data (q_rd)
   );

   // user row update uses old item value as partner, and the reverse
   sgdmf_update u_p_update (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (u1_v_ff),
      .in_k           (u1_k_ff),
      .x              ($signed(p_rd)),
      .y              ($signed(q_rd)),
      .err            (err_ff),
      .learn_rate     (lr_ff),
      .regularization (reg_ff),
      .result         (p_upd)
   );

   sgdmf_update u_q_update (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (u1_v_ff),
      .in_k           (u1_k_ff),
      .x              ($signed(q_rd)),
      .y              ($signed(p_rd)),
      .err            (err_ff),
      .learn_rate     (lr_ff),
      .regularization (reg_ff),
      .result         (q_upd)
   );

   // checks
   `SGDMF_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `SGDMF_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `SGDMF_ASSERT_NOW(a_strobe_after_resp, clock, reset, rsp_strobe, $past(state_ff == sgdmf_pkg::ST_RESP))
   `SGDMF_ASSERT_NOW(a_upd_wr_phase, clock, reset, p_upd.wr_en, (state_ff == sgdmf_pkg::ST_UPD || state_ff == sgdmf_pkg::ST_UPD_WAIT))

endmodule

FILE: tb/sgd_matrix_factorization_update_unit_checker.sv
`timescale 1ns / 100ps
// checker for the sgd matrix factorisation update unit: watches request, result and csr traffic
// keeps its own factor tables and registers; depends on sgdmf_pkg
module sgd_matrix_factorization_update_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  sgdmf_pkg::req_type req_data,
   input  logic               rsp_strobe,
   input  sgdmf_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 fail_count,
   output int                 pending
);

   localparam int REG_LEARN_RATE = 0;
   localparam int REG_REGULARIZE = 1;

   logic [15:0]         alpha;
   logic [15:0]         beta;
   longint              user_row_mem [sgdmf_pkg::USERS*sgdmf_pkg::FACTORS];
   longint              item_row_mem [sgdmf_pkg::ITEMS*sgdmf_pkg::FACTORS];
   sgdmf_pkg::rsp_type  result_queue [$];

   function automatic longint clamp24(input longint x, inout logic flag);
      if (x > 64'sd8388607) begin
         flag = 1'b1;
         return 64'sd8388607;
      end
      if (x < -64'sd8388608) begin
         flag = 1'b1;
         return -64'sd8388608;
      end
      return x;
   endfunction

   // one element step from the old values, rounded half up to q8.16
   function automatic longint step_factor(input longint x, input longint y, input longint e,
                                          inout logic flag);
      longint t, t_hi, t_lo, a, z;
      t    = 2 * e * y - longint'(beta) * x;
      t_hi = t >>> 16;
      t_lo = t - t_hi * 65536;
      a    = longint'(alpha);
      z    = a * t_hi + ((a * t_lo + (64'sd1 <<< 31)) >>> 16);
      return clamp24(x + (z >>> 16), flag);
   endfunction

   // apply one request to the model tables and work out its result
   function automatic sgdmf_pkg::rsp_type apply_request(input sgdmf_pkg::req_type r);
      sgdmf_pkg::rsp_type res;
      logic    flag;
      longint  acc, pred, e, p, q;
      int      ubase, ibase;
      flag  = 1'b0;
      acc   = 0;
      ubase = int'(r.user_index) * sgdmf_pkg::FACTORS;
      ibase = int'(r.item_index) * sgdmf_pkg::FACTORS;
      res.out_value = '0;
      case (sgdmf_pkg::op_type'(r.operation))
         sgdmf_pkg::OP_LOAD_USER: begin
            if (r.factor_index < sgdmf_pkg::FACTORS)
               user_row_mem[ubase + r.factor_index] = r.in_value;
         end
         sgdmf_pkg::OP_LOAD_ITEM: begin
            if (r.factor_index < sgdmf_pkg::FACTORS)
               item_row_mem[ibase + r.factor_index] = r.in_value;
         end
         default: begin
            for (int k = 0; k < sgdmf_pkg::FACTORS; k++)
               acc += user_row_mem[ubase + k] * item_row_mem[ibase + k];
            pred = clamp24((acc + (64'sd1 <<< 15)) >>> 16, flag);
            if (sgdmf_pkg::op_type'(r.operation) == sgdmf_pkg::OP_PREDICT) begin
               res.out_value = pred[23:0];
            end else begin
               e = clamp24(longint'(r.in_value) - pred, flag);
               for (int k = 0; k < sgdmf_pkg::FACTORS; k++) begin
                  p = user_row_mem[ubase + k];
                  q = item_row_mem[ibase + k];
                  user_row_mem[ubase + k] = step_factor(p, q, e, flag);
                  item_row_mem[ibase + k] = step_factor(q, p, e, flag);
               end
               res.out_value = e[23:0];
            end
         end
      endcase
      res.saturated = flag;
      return res;
   endfunction

   assign pending = result_queue.size();

   always @(posedge clock) begin
      sgdmf_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         alpha      <= 16'd13;
         beta       <= 16'd1311;
         fail_count <= 0;
         result_queue.delete();
      end else begin
         // results first: they always belong to older requests
         if (rsp_strobe) begin
            if (result_queue.size() == 0) begin
               $error("unexpected result out_value=%0d", rsp_data.out_value);
               errs++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_data.out_value !== want.out_value) begin
                  $error("out_value expected %0d actual %0d", want.out_value,
                         rsp_data.out_value);
                  errs++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated expected %0b actual %0b", want.saturated,
                         rsp_data.saturated);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
         if (start && !busy)
            result_queue.insert(result_queue.size(), apply_request(req_data));
         // csr writes
         if (psel && penable && pwrite && pready) begin
            case (int'(paddr >> 2))
               REG_LEARN_RATE: alpha <= pwdata[15:0];
               REG_REGULARIZE: beta  <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: tb/sgd_matrix_factorization_update_unit_tb.sv
`timescale 1ns / 100ps
// top of the sgd matrix factorisation update unit testbench: clock, reset, stimulus, verdict
// depends on sgdmf_pkg, the unit and sgd_matrix_factorization_update_unit_checker
module sgd_matrix_factorization_update_unit_tb;

   localparam int ADDR_LEARN_RATE = 0;
   localparam int ADDR_REGULARIZE = 4;
   localparam int TRAIN_DRAIN     = 60;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int RANDOM_ITEMS    = 1750;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   sgdmf_pkg::req_type req_data;
   logic               rsp_strobe;
   sgdmf_pkg::rsp_type rsp_data;
   logic               psel, penable, pwrite, pready;
   logic [2:0]         paddr;
   logic [31:0]        pwdata, prdata;
   int                 fail_count;
   int                 pending;
   int                 cycle_count;
   logic [15:0]        user_loaded [sgdmf_pkg::USERS];
   logic [15:0]        item_loaded [sgdmf_pkg::ITEMS];
   int                 user_ready [$];
   int                 item_ready [$];
   bit                 no_idle;

   sgd_matrix_factorization_update_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sgd_matrix_factorization_update_unit_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // send one request and hold it until taken; busy only moves at rising edges
   task automatic send_request(input sgdmf_pkg::op_type op, input int user, input int item,
                               input int k, input logic [23:0] value);
      bit taken;
      int gap;
      if (!no_idle && $urandom_range(99) < 16) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_data.operation    <= op;
      req_data.user_index   <= user[9:0];
      req_data.item_index   <= item[9:0];
      req_data.factor_index <= k[3:0];
      req_data.in_value     <= value;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      if (op == sgdmf_pkg::OP_LOAD_USER) begin
         user_loaded[user][k] = 1'b1;
         if (&user_loaded[user] && !(user inside {user_ready}))
            user_ready.insert(user_ready.size(), user);
      end else if (op == sgdmf_pkg::OP_LOAD_ITEM) begin
         item_loaded[item][k] = 1'b1;
         if (&item_loaded[item] && !(item inside {item_ready}))
            item_ready.insert(item_ready.size(), item);
      end
   endtask

   // wait for the unit to go quiet
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TRAIN_DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(input int addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr[2:0];
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_rates(input logic [15:0] a, input logic [15:0] b);
      drain();
      csr_write(ADDR_LEARN_RATE, {16'h0, a});
      csr_write(ADDR_REGULARIZE, {16'h0, b});
   endtask

   function automatic logic [23:0] factor_value;
      int r;
      r = $urandom_range(99);
      if (r < 70) return 24'($signed($urandom_range(131072)) - 65536);
      return 24'($urandom);
   endfunction

   function automatic logic [23:0] rating_value;
      if ($urandom_range(99) < 80) return 24'($urandom_range(5 << 16));
      return 24'($urandom);
   endfunction

   initial begin
      int fill_users [4];
      int fill_items [4];
      int user, item, pick, k;
      fill_users = '{0, 1023, 341, 682};
      fill_items = '{0, 1023, 512, 77};
      foreach (user_loaded[i]) user_loaded[i] = '0;
      foreach (item_loaded[i]) item_loaded[i] = '0;
      no_idle  = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill a few rows of both tables
      foreach (fill_users[i])
         for (k = 0; k < sgdmf_pkg::FACTORS; k++)
            send_request(sgdmf_pkg::OP_LOAD_USER, fill_users[i], 0, k, factor_value());
      foreach (fill_items[i])
         for (k = 0; k < sgdmf_pkg::FACTORS; k++)
            send_request(sgdmf_pkg::OP_LOAD_ITEM, 0, fill_items[i], k, factor_value());

      // directed: predict and train at the extremes under reset rates
      send_request(sgdmf_pkg::OP_PREDICT, 0, 0, 0, 24'h0);
      send_request(sgdmf_pkg::OP_TRAIN, 1023, 1023, 15, 24'h7fffff);
      send_request(sgdmf_pkg::OP_TRAIN, 0, 1023, 0, 24'h800000);
      send_request(sgdmf_pkg::OP_PREDICT, 1023, 0, 15, 24'hffffff);
      // extreme factors drive the prediction into saturation both ways
      send_request(sgdmf_pkg::OP_LOAD_USER, 341, 0, 0, 24'h7fffff);
      send_request(sgdmf_pkg::OP_LOAD_ITEM, 0, 512, 0, 24'h7fffff);
      send_request(sgdmf_pkg::OP_LOAD_USER, 341, 0, 15, 24'h7fffff);
      send_request(sgdmf_pkg::OP_LOAD_ITEM, 0, 512, 15, 24'h7fffff);
      send_request(sgdmf_pkg::OP_PREDICT, 341, 512, 0, 24'h0);
      send_request(sgdmf_pkg::OP_TRAIN, 341, 512, 0, 24'h800000);
      send_request(sgdmf_pkg::OP_LOAD_ITEM, 0, 77, 0, 24'h800000);
      send_request(sgdmf_pkg::OP_LOAD_USER, 682, 0, 0, 24'h7fffff);
      send_request(sgdmf_pkg::OP_PREDICT, 682, 77, 3, 24'h123456);
      send_request(sgdmf_pkg::OP_TRAIN, 682, 77, 3, 24'h7fffff);
      // sender holds off until every result is back
      drain();
      set_rates(16'hffff, 16'hffff);
      send_request(sgdmf_pkg::OP_TRAIN, 0, 0, 0, 24'h010000);
      send_request(sgdmf_pkg::OP_TRAIN, 1023, 512, 0, 24'h800000);
      set_rates(16'h0000, 16'h0000);
      send_request(sgdmf_pkg::OP_TRAIN, 0, 77, 0, 24'h7fffff);
      send_request(sgdmf_pkg::OP_PREDICT, 0, 77, 0, 24'h0);

      // random traffic, mostly train and predict on loaded rows
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 350 == 0) begin
            case ((n / 350) % 4)
               0: set_rates(16'd13, 16'd1311);
               1: set_rates(16'($urandom), 16'($urandom));
               2: set_rates(16'hffff, 16'h0000);
               default: set_rates(16'($urandom_range(2000)), 16'($urandom_range(4000)));
            endcase
         end
         no_idle = (n >= 700 && n < 950);
         pick = $urandom_range(99);
         user = user_ready[$urandom_range(user_ready.size() - 1)];
         item = item_ready[$urandom_range(item_ready.size() - 1)];
         if (pick < 20) begin
            if ($urandom_range(3) == 0) user = $urandom_range(sgdmf_pkg::USERS - 1);
            send_request(sgdmf_pkg::OP_LOAD_USER, user, $urandom_range(sgdmf_pkg::ITEMS - 1),
                         $urandom_range(15), factor_value());
         end else if (pick < 40) begin
            if ($urandom_range(3) == 0) item = $urandom_range(sgdmf_pkg::ITEMS - 1);
            send_request(sgdmf_pkg::OP_LOAD_ITEM, $urandom_range(sgdmf_pkg::USERS - 1), item,
                         $urandom_range(15), factor_value());
         end else if (pick < 60) begin
            send_request(sgdmf_pkg::OP_PREDICT, user, item, $urandom_range(15),
                         24'($urandom));
         end else begin
            send_request(sgdmf_pkg::OP_TRAIN, user, item, $urandom_range(15),
                         rating_value());
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TRAIN_DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
